[src/gha_pkg.sv]
// ----------------------------------------------------------------------------
// GHASH accumulator package
// Shared types, constants and the GF(2^128) multiply-by-x^k helper.
// ----------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

   // GF(2^128) block and digit geometry
   localparam int BlockBits = 128;
   localparam int HalfBits  = 64;
   localparam int DigitBits = 16;
   localparam int Digits    = BlockBits / DigitBits;
   localparam int CntBits   = $clog2(Digits);
   localparam int Bytes     = BlockBits / 8;

   // Field widths
   localparam int CountBits = 5;
   localparam int CsrIdxBits = 2;

   // Reduction term for x^128 in reflected bit order (x^0 sits in bit 127)
   localparam logic [BlockBits-1:0] GfRed = {8'hE1, {(BlockBits-8){1'b0}}};

   // CSR register indexes
   localparam logic [CsrIdxBits-1:0] CsrKeyHi = 2'd0;
   localparam logic [CsrIdxBits-1:0] CsrKeyLo = 2'd1;

   typedef logic [BlockBits-1:0] gf_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } gha_state_type;

   // v * x^k, 0 <= k <= DigitBits. Bits shifted out past x^127 fold back
   // through R; with k <= 16 the folded terms stay below x^128.
   function automatic gf_type gf_mulxk(input gf_type v, input int k);
      gf_type r;
      r = v >> k;
      for (int m = 0; m < DigitBits; m++) begin
         if ((m < k) && v[m]) begin
            r = r ^ (GfRed >> (k - 1 - m));
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[src/gha_digit_mul.sv]
// ----------------------------------------------------------------------------
// GHASH digit multiplier step
// One Horner step: z_next = z * x^16 + digit * H in GF(2^128).
// ----------------------------------------------------------------------------
`default_nettype none

module gha_digit_mul (
   input  wire  gha_pkg::gf_type                   z_i,
   input  wire  gha_pkg::gf_type                   key_i,
   input  wire  logic [gha_pkg::DigitBits-1:0]     digit_i,
   output gha_pkg::gf_type                         z_next_o
);

   gha_pkg::gf_type acc;

   // digit bit 15-j carries the coefficient that multiplies H * x^j
   always_comb begin
      acc = gha_pkg::gf_mulxk(z_i, gha_pkg::DigitBits);
      for (int j = 0; j < gha_pkg::DigitBits; j++) begin
         if (digit_i[gha_pkg::DigitBits-1-j]) begin
            acc = acc ^ gha_pkg::gf_mulxk(key_i, j);
         end
      end
   end

   assign z_next_o = acc;

endmodule

`default_nettype wire

[src/gha_operand.sv]
// ----------------------------------------------------------------------------
// GHASH operand former
// Masks trailing bytes of the data block, applies clear, XORs into the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_operand (
   input  wire  gha_pkg::gf_type                   acc_i,
   input  wire  gha_pkg::gf_type                   block_i,
   input  wire  logic [gha_pkg::CountBits-1:0]     byte_count_i,
   input  wire  logic                              clear_i,
   output gha_pkg::gf_type                         base_o,     // accumulator after clear
   output gha_pkg::gf_type                         operand_o,  // base xor masked block
   output logic                                    empty_o     // no bytes to absorb
);

   logic [gha_pkg::CountBits-1:0] n_sat;
   gha_pkg::gf_type               mask;

   assign n_sat = (byte_count_i > gha_pkg::CountBits'(gha_pkg::Bytes))
                ? gha_pkg::CountBits'(gha_pkg::Bytes) : byte_count_i;

   // byte 0 sits in the top byte lane
   always_comb begin
      mask = '0;
      for (int b = 0; b < gha_pkg::Bytes; b++) begin
         mask[gha_pkg::BlockBits-1-8*b -: 8] =
            (gha_pkg::CountBits'(b) < n_sat) ? 8'hFF : 8'h00;
      end
   end

   assign base_o    = clear_i ? '0 : acc_i;
   assign operand_o = base_o ^ (block_i & mask);
   assign empty_o   = (n_sat == '0);

endmodule

`default_nettype wire

[src/ghash_accumulator_core.sv]
// ----------------------------------------------------------------------------
// GHASH accumulator core
// Absorbs 128-bit blocks into a running GHASH sum, multiplying by the hash
// subkey H in GF(2^128) with a shared 128x16 digit-serial multiplier.
// ----------------------------------------------------------------------------
//
//  channel | direction | transfer carries
//  --------+-----------+-----------------------------------------------------
//  req_    | in        | data block, valid byte count, clear flag (tuser)
//  rsp_    | out       | updated accumulator (digest)
//  csr_    | in        | hash subkey halves, index 0 = high, 1 = low
//
//  A block with a nonzero byte count passes through accept, the digit loop
//  over the eight 16-bit multiplier digits, and write-back; a zero count goes
//  from accept straight to write-back. req_tready is high only in idle; a
//  stalled rsp_ holds the finished sum in the write-back state until the
//  previous result is taken. Reset clears the accumulator, key and control
//  state; no clearing pass. csr_ is always ready; the user must write it only
//  while the core is idle, which the core itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module ghash_accumulator_core (
   input  wire  logic          clock,
   input  wire  logic          reset,

   input  wire  logic          req_tvalid,
   output logic                req_tready,
   input  wire  logic [135:0]  req_tdata,   // block_hi[63:0], block_lo[127:64],
                                            // byte_count[132:128], zero pad
   input  wire  logic          req_tuser,   // clear

   output logic                rsp_tvalid,
   input  wire  logic          rsp_tready,
   output logic [127:0]        rsp_tdata,   // digest_hi[63:0], digest_lo[127:64]

   input  wire  logic          csr_valid,
   output logic                csr_ready,
   input  wire  logic [gha_pkg::CsrIdxBits-1:0] csr_index,
   input  wire  logic [gha_pkg::HalfBits-1:0]   csr_data
);

   localparam int HB = gha_pkg::HalfBits;
   localparam int DB = gha_pkg::DigitBits;

   // request fields
   logic [HB-1:0]                  block_hi;
   logic [HB-1:0]                  block_lo;
   logic [gha_pkg::CountBits-1:0]  byte_count;
   logic                           clear;

   assign block_hi   = req_tdata[HB-1:0];
   assign block_lo   = req_tdata[2*HB-1:HB];
   assign byte_count = req_tdata[2*HB +: gha_pkg::CountBits];
   assign clear      = req_tuser;

   // key registers
   logic [HB-1:0] key_hi_ff, key_hi_in;
   logic [HB-1:0] key_lo_ff, key_lo_in;

   // sequencer and datapath registers
   gha_pkg::gha_state_type         state_ff, state_in;
   logic [gha_pkg::CntBits-1:0]    cnt_ff, cnt_in;
   gha_pkg::gf_type                acc_ff, acc_in;     // GHASH sum
   gha_pkg::gf_type                x_ff, x_in;         // multiplier operand, digits out low
   gha_pkg::gf_type                z_ff, z_in;         // partial product
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [2*HB-1:0]                rsp_data_ff, rsp_data_in;

   gha_pkg::gf_type                base;
   gha_pkg::gf_type                operand;
   logic                           empty;
   gha_pkg::gf_type                z_step;
   logic                           req_xfer;
   logic                           slot_free;

   assign csr_ready = 1'b1;

   always_comb begin
      key_hi_in = key_hi_ff;
      key_lo_in = key_lo_ff;
      if (csr_valid) begin
         unique case (csr_index)
            gha_pkg::CsrKeyHi: key_hi_in = csr_data;
            gha_pkg::CsrKeyLo: key_lo_in = csr_data;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   gha_operand u_operand (
      .acc_i        (acc_ff),
      .block_i      ({block_hi, block_lo}),
      .byte_count_i (byte_count),
      .clear_i      (clear),
      .base_o       (base),
      .operand_o    (operand),
      .empty_o      (empty)
   );

   // shared multiplier: one 16-bit digit of the operand per cycle,
   // last digit first (Horner order)
   gha_digit_mul u_digit_mul (
      .z_i      (z_ff),
      .key_i    ({key_hi_ff, key_lo_ff}),
      .digit_i  (x_ff[DB-1:0]),
      .z_next_o (z_step)
   );

   assign req_tready = (state_ff == gha_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      z_in         = z_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         gha_pkg::ST_IDLE: begin
            if (req_xfer) begin
               cnt_in = '0;
               x_in   = operand;
               if (empty) begin
                  // nothing to absorb: result is the (possibly cleared) sum
                  z_in     = base;
                  state_in = gha_pkg::ST_HOLD;
               end else begin
                  z_in     = '0;
                  state_in = gha_pkg::ST_RUN;
               end
            end
         end
         gha_pkg::ST_RUN: begin
            z_in   = z_step;
            x_in   = x_ff >> DB;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == gha_pkg::CntBits'(gha_pkg::Digits - 1)) begin
               state_in = gha_pkg::ST_HOLD;
            end
         end
         gha_pkg::ST_HOLD: begin
            // write back once the output register is free
            if (slot_free) begin
               acc_in       = z_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {z_ff[HB-1:0], z_ff[2*HB-1:HB]};
               state_in     = gha_pkg::ST_IDLE;
            end
         end
         default: state_in = gha_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gha_pkg::ST_IDLE;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         key_hi_ff    <= '0;
         key_lo_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         key_hi_ff    <= key_hi_in;
         key_lo_ff    <= key_lo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      z_ff        <= z_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // digit counter only moves while the multiplier runs
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != gha_pkg::ST_RUN) |-> (cnt_ff == '0))
      else $error("digit counter nonzero outside run");

   // a new result only comes from the write-back state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == gha_pkg::ST_HOLD))
      else $error("result raised without write-back");

   // a block with bytes to absorb starts the multiplier from digit zero
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !empty) |=> (state_ff == gha_pkg::ST_RUN && cnt_ff == '0))
      else $error("multiplier did not start on accepted block");

   // accumulator changes only at write-back
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) != gha_pkg::ST_HOLD) |-> $stable(acc_ff))
      else $error("accumulator changed outside write-back");

endmodule

`default_nettype wire
